[rtl/teq_pkg.sv]
// Shared widths and codes for the timed event queue.
`timescale 1ns / 1ps

package teq_pkg;

    localparam int TIME_W    = 32;
    localparam int DELAY_W   = 24;
    localparam int HANDLER_W = 4;
    localparam int STATUS_W  = 2;

    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    localparam logic [STATUS_W-1:0] ST_NONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FIRED     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SCHEDULED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED   = 2'd3;

endpackage

[rtl/timed_event_queue.sv]
// Timed event queue: sorted circular buffer of pending events in one memory.
//
//   channel | direction | handshake          | fields
//   --------+-----------+--------------------+--------------------------------------------
//   in      | input     | in_valid, in_stall | command, current_time, delay, handler, payload
//   out     | output    | out_valid,out_stall| status, fired_handler, fired_payload, queue_level
//
// The entries form a circular buffer in the entry memory, earliest due at the head.
// A tick transaction goes through accept, head read and result.
// A schedule transaction walks down from the tail, moving each entry whose due time is the
// same or later up one slot, and then writes the new entry into the slot left free.
// A schedule into an empty or full queue and a tick on an empty queue go straight to the result.
// Reset empties the queue at once; the memory needs no clearing pass.
// The result sits in an output register, so a stalled output blocks the block only when
// the next result is ready and the previous one has not been taken.
`timescale 1ns / 1ps

module timed_event_queue #(
    parameter int QUEUE_DEPTH   = 32,
    parameter int PAYLOAD_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [teq_pkg::TIME_W-1:0]          current_time,
    input  logic [teq_pkg::DELAY_W-1:0]         delay,
    input  logic [teq_pkg::HANDLER_W-1:0]       handler,
    input  logic [PAYLOAD_WIDTH-1:0]            payload,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [teq_pkg::STATUS_W-1:0]        status,
    output logic [teq_pkg::HANDLER_W-1:0]       fired_handler,
    output logic [PAYLOAD_WIDTH-1:0]            fired_payload,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]    queue_level
);

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W  = teq_pkg::TIME_W;
    localparam int HND_W   = teq_pkg::HANDLER_W;
    localparam int ENTRY_W = TIME_W + HND_W + PAYLOAD_WIDTH;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_PLACE = 3'd2;
    localparam logic [2:0] S_TICK  = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
        ptr_inc = (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] p);
        ptr_dec = (p == '0) ? LAST_IDX : p - 1'b1;
    endfunction

    logic [2:0]                      state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [IDX_W-1:0]                head_reg, head_next;
    logic [IDX_W-1:0]                tail_reg, tail_next;
    logic [IDX_W-1:0]                ptr_reg, ptr_next;
    logic [CNT_W-1:0]                left_reg, left_next;
    logic [TIME_W-1:0]               due_reg, due_next;
    logic [TIME_W-1:0]               now_reg, now_next;
    logic [HND_W-1:0]                hnd_reg, hnd_next;
    logic [PAYLOAD_WIDTH-1:0]        pay_reg, pay_next;
    logic [teq_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [HND_W-1:0]                res_hnd_reg, res_hnd_next;
    logic [PAYLOAD_WIDTH-1:0]        res_pay_reg, res_pay_next;
    logic                            out_valid_reg, out_valid_next;
    logic [teq_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [HND_W-1:0]                fired_handler_reg, fired_handler_next;
    logic [PAYLOAD_WIDTH-1:0]        fired_payload_reg, fired_payload_next;
    logic [CNT_W-1:0]                level_reg, level_next;

    logic                            wr_en;
    logic [IDX_W-1:0]                wr_addr;
    logic [ENTRY_W-1:0]              wr_data;
    logic                            rd_en;
    logic [IDX_W-1:0]                rd_addr;
    logic [ENTRY_W-1:0]              rd_data;

    logic [TIME_W:0]                 due_sum;
    logic [TIME_W-1:0]               due_sat;
    logic [TIME_W-1:0]               rd_due;
    logic [HND_W-1:0]                rd_hnd;
    logic [PAYLOAD_WIDTH-1:0]        rd_pay;
    logic                            in_take;

    teq_entry_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;

    assign due_sum = {1'b0, current_time} + {{(TIME_W + 1 - teq_pkg::DELAY_W){1'b0}}, delay};
    assign due_sat = due_sum[TIME_W] ? {TIME_W{1'b1}} : due_sum[TIME_W-1:0];

    assign rd_due = rd_data[ENTRY_W-1 -: TIME_W];
    assign rd_hnd = rd_data[PAYLOAD_WIDTH +: HND_W];
    assign rd_pay = rd_data[PAYLOAD_WIDTH-1:0];

    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        head_next          = head_reg;
        tail_next          = tail_reg;
        ptr_next           = ptr_reg;
        left_next          = left_reg;
        due_next           = due_reg;
        now_next           = now_reg;
        hnd_next           = hnd_reg;
        pay_next           = pay_reg;
        res_status_next    = res_status_reg;
        res_hnd_next       = res_hnd_reg;
        res_pay_next       = res_pay_reg;
        out_valid_next     = out_valid_reg && out_stall;
        status_next        = status_reg;
        fired_handler_next = fired_handler_reg;
        fired_payload_next = fired_payload_reg;
        level_next         = level_reg;
        wr_en              = 1'b0;
        wr_addr            = tail_reg;
        wr_data            = {due_reg, hnd_reg, pay_reg};
        rd_en              = 1'b0;
        rd_addr            = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    due_next     = due_sat;
                    now_next     = current_time;
                    hnd_next     = handler;
                    pay_next     = payload;
                    res_hnd_next = '0;
                    res_pay_next = '0;
                    if (command == teq_pkg::CMD_SCHEDULE)
                    begin
                        if (count_reg == FULL_CNT)
                        begin
                            res_status_next = teq_pkg::ST_DROPPED;
                            state_next      = S_RESP;
                        end
                        else if (count_reg == '0)
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = tail_reg;
                            wr_data         = {due_sat, handler, payload};
                            tail_next       = ptr_inc(tail_reg);
                            count_next      = count_reg + 1'b1;
                            res_status_next = teq_pkg::ST_SCHEDULED;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = ptr_dec(tail_reg);
                            ptr_next   = ptr_dec(tail_reg);
                            left_next  = count_reg;
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = teq_pkg::ST_NONE;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            state_next = S_TICK;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_inc(ptr_reg);
                if (rd_due >= due_reg)
                begin
                    wr_data = rd_data;
                    if (left_reg == ONE_CNT)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = ptr_dec(ptr_reg);
                        ptr_next   = ptr_dec(ptr_reg);
                        left_next  = left_reg - 1'b1;
                    end
                end
                else
                begin
                    tail_next       = ptr_inc(tail_reg);
                    count_next      = count_reg + 1'b1;
                    res_status_next = teq_pkg::ST_SCHEDULED;
                    state_next      = S_RESP;
                end
            end
            S_PLACE:
            begin
                wr_en           = 1'b1;
                wr_addr         = ptr_reg;
                tail_next       = ptr_inc(tail_reg);
                count_next      = count_reg + 1'b1;
                res_status_next = teq_pkg::ST_SCHEDULED;
                state_next      = S_RESP;
            end
            S_TICK:
            begin
                if (rd_due < now_reg)
                begin
                    head_next       = ptr_inc(head_reg);
                    count_next      = count_reg - 1'b1;
                    res_status_next = teq_pkg::ST_FIRED;
                    res_hnd_next    = rd_hnd;
                    res_pay_next    = rd_pay;
                end
                else
                begin
                    res_status_next = teq_pkg::ST_NONE;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next     = 1'b1;
                    status_next        = res_status_reg;
                    fired_handler_next = res_hnd_reg;
                    fired_payload_next = res_pay_reg;
                    level_next         = count_reg;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg           <= ptr_next;
        left_reg          <= left_next;
        due_reg           <= due_next;
        now_reg           <= now_next;
        hnd_reg           <= hnd_next;
        pay_reg           <= pay_next;
        res_status_reg    <= res_status_next;
        res_hnd_reg       <= res_hnd_next;
        res_pay_reg       <= res_pay_next;
        status_reg        <= status_next;
        fired_handler_reg <= fired_handler_next;
        fired_payload_reg <= fired_payload_next;
        level_reg         <= level_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign fired_handler = fired_handler_reg;
    assign fired_payload = fired_payload_reg;
    assign queue_level   = level_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("Entry count exceeds the queue depth.");

    a_scan_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_PLACE) |-> (count_reg != '0 && count_reg != FULL_CNT))
        else $error("Insertion walk runs on an empty or full queue.");

    a_fire_moves_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TICK && rd_due < now_reg) |=> (head_reg == ptr_inc($past(head_reg))))
        else $error("A fired entry did not advance the head.");

    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != teq_pkg::ST_FIRED)
            |-> (fired_handler_reg == '0 && fired_payload_reg == '0))
        else $error("Fired fields are nonzero on a transaction that fired nothing.");
`endif

endmodule

[rtl/teq_entry_ram.sv]
// Entry memory of the timed event queue: one write port, one registered read port.
`timescale 1ns / 1ps

module teq_entry_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 52
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
